FILE: rtl/core/slt_pkg.sv
// Shared types and operation codes for the sorted list table.
// No dependencies; used by the top level.
`timescale 1ns / 1ps

package slt_pkg;

  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_LOOKUP = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned FIELD_W = 7;

  typedef struct packed {
    logic [1:0]                func;
    logic signed [VALUE_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic               accepted;
    logic               full_res;
    logic               found;
    logic [FIELD_W-1:0] position;
    logic [FIELD_W-1:0] entry_count;
    logic               is_empty;
  } rsp_t;

endpackage

FILE: rtl/core/slt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module slt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/sorted_list_table_top.sv
// Sorted list table top level: request/response channels, sequencer, entry RAM.
// Depends on slt_pkg and slt_ram.
`timescale 1ns / 1ps

// Keeps up to CAPACITY signed 32-bit values in ascending order in a single RAM.
// One request is worked at a time and req_stall stays high until its response
// has been handed to the output register; the next request may be taken while
// that response still waits on rsp_stall. Insert walks the stored entries from
// the tail toward the head, moving each entry that is greater or equal one slot
// up, and then writes the new value into the gap. The one RAM read port delivers
// one entry per cycle to the walk. Lookup walks from the head, one entry per
// cycle, stopping on the first match. Clear, an unused code, and an insert
// into a full table do no walk. Every response carries the entry count after
// the request and an empty flag.
module sorted_list_table_top #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  slt_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output slt_pkg::rsp_t rsp
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = (CW > slt_pkg::FIELD_W) ? CW : slt_pkg::FIELD_W;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_INS  = 5'b00010,
    ST_PUT  = 5'b00100,
    ST_LKP  = 5'b01000,
    ST_RES  = 5'b10000
  } state_t;

  state_t state, state_next;

  // Entry count and walk index; both must be able to hold CAPACITY itself.
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] idx, idx_next;
  logic [CW-1:0] idx_inc;

  // Request value and the result fields under construction.
  logic signed [slt_pkg::VALUE_W-1:0] key, key_next;
  logic          r_accepted, r_accepted_next;
  logic          r_full, r_full_next;
  logic          r_found, r_found_next;
  logic [CW-1:0] r_pos, r_pos_next;

  // Entry RAM ports.
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [slt_pkg::VALUE_W-1:0] ram_wdata;
  logic [AW-1:0]               ram_raddr;
  logic [slt_pkg::VALUE_W-1:0] ram_rdata;

  // Output register.
  logic          rsp_load;
  logic [XW-1:0] pos_ext, count_ext;

  assign idx_inc   = idx + CW'(1);
  // Always read the entry the sequencer looks at next cycle.
  assign ram_raddr = idx_next[AW-1:0];
  assign req_stall = (state != ST_IDLE);
  assign rsp_load  = (state == ST_RES) && (!rsp_valid || !rsp_stall);
  assign pos_ext   = XW'(r_pos);
  assign count_ext = XW'(count);

  slt_ram #(
    .WIDTH (slt_pkg::VALUE_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next      = state;
    count_next      = count;
    idx_next        = idx;
    key_next        = key;
    r_accepted_next = r_accepted;
    r_full_next     = r_full;
    r_found_next    = r_found;
    r_pos_next      = r_pos;
    ram_we          = 1'b0;
    ram_waddr       = idx[AW-1:0];
    ram_wdata       = key;

    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          key_next        = req.value;
          r_accepted_next = 1'b0;
          r_full_next     = 1'b0;
          r_found_next    = 1'b0;
          r_pos_next      = '0;
          case (req.func)
            slt_pkg::FUNC_INSERT: begin
              if (count == CW'(CAPACITY)) begin
                // Refuse: table full, nothing changes.
                r_full_next = 1'b1;
                state_next  = ST_RES;
              end else if (count == '0) begin
                idx_next   = '0;
                state_next = ST_PUT;
              end else begin
                // Start at the tail and walk down.
                idx_next   = count - CW'(1);
                state_next = ST_INS;
              end
            end
            slt_pkg::FUNC_LOOKUP: begin
              r_accepted_next = 1'b1;
              idx_next        = '0;
              state_next      = (count == '0) ? ST_RES : ST_LKP;
            end
            slt_pkg::FUNC_CLEAR: begin
              count_next      = '0;
              r_accepted_next = 1'b1;
              state_next      = ST_RES;
            end
            default: begin
              state_next = ST_RES;
            end
          endcase
        end
      end

      ST_INS: begin
        if ($signed(ram_rdata) >= key) begin
          // Move this entry one slot up; equal entries go behind the new one.
          ram_we    = 1'b1;
          ram_waddr = idx_inc[AW-1:0];
          ram_wdata = ram_rdata;
          if (idx == '0) begin
            state_next = ST_PUT;
          end else begin
            idx_next = idx - CW'(1);
          end
        end else begin
          // Gap sits just above the first smaller entry.
          idx_next   = idx_inc;
          state_next = ST_PUT;
        end
      end

      ST_PUT: begin
        ram_we          = 1'b1;
        ram_waddr       = idx[AW-1:0];
        ram_wdata       = key;
        count_next      = count + CW'(1);
        r_accepted_next = 1'b1;
        state_next      = ST_RES;
      end

      ST_LKP: begin
        if ($signed(ram_rdata) == key) begin
          r_found_next = 1'b1;
          r_pos_next   = idx_inc;
          state_next   = ST_RES;
        end else if (idx_inc == count) begin
          state_next = ST_RES;
        end else begin
          idx_next = idx_inc;
        end
      end

      ST_RES: begin
        // Hold until the output register is free.
        if (rsp_load) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx        <= idx_next;
    key        <= key_next;
    r_accepted <= r_accepted_next;
    r_full     <= r_full_next;
    r_found    <= r_found_next;
    r_pos      <= r_pos_next;
    if (rsp_load) begin
      rsp.accepted    <= r_accepted;
      rsp.full_res    <= r_full;
      rsp.found       <= r_found;
      rsp.position    <= pos_ext[slt_pkg::FIELD_W-1:0];
      rsp.entry_count <= count_ext[slt_pkg::FIELD_W-1:0];
      rsp.is_empty    <= (count == '0);
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    $past(rst) || count == $past(count) || count == $past(count) + CW'(1) || count == '0)
    else $error("entry count moved by other than one insert or a clear");

  a_full_refuse: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && req_valid && req.func == slt_pkg::FUNC_INSERT
     && count == CW'(CAPACITY)) |=> (state == ST_RES && r_full && !r_accepted))
    else $error("insert into full table not refused");

  a_hit_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RES && r_found) |-> (r_pos != '0 && r_pos <= count))
    else $error("lookup hit position outside stored entries");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == ST_INS || state == ST_PUT) && (idx < CW'(CAPACITY)))
    else $error("entry write outside an insert walk");
`endif

endmodule
